// ----- hw/rtl/click_type_blink_rate_selector_defines.svh -----
// ----------------------------------------------------------------------------
// Click type blink rate selector - assertion macros
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef CLICK_TYPE_BLINK_RATE_SELECTOR_DEFINES_SVH
`define CLICK_TYPE_BLINK_RATE_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Property on an explicit clock and active-low reset.
`define CTBRS_ASSERT_CLK(lbl, clock, resetn, prop) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (prop)) \
        else $error("ctbrs assertion failed");

// Property on the block clock and reset.
`define CTBRS_ASSERT(lbl, prop) \
    `CTBRS_ASSERT_CLK(lbl, clk, rst_n, prop)

`else

`define CTBRS_ASSERT_CLK(lbl, clock, resetn, prop)

`define CTBRS_ASSERT(lbl, prop)

`endif

`endif

// ----- hw/rtl/ctbrs_pkg.sv -----
// ----------------------------------------------------------------------------
// ctbrs_pkg
// Types and codes shared by the click type blink rate selector.
// ----------------------------------------------------------------------------
package ctbrs_pkg;

    // click phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_REL1   = 3'd1;
    localparam logic [2:0] PH_WINDOW = 3'd2;
    localparam logic [2:0] PH_REL2   = 3'd3;
    localparam logic [2:0] PH_COOL   = 3'd4;

    // click event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RATE_PERIOD_0 = 3'd0;
    localparam logic [2:0] REG_RATE_PERIOD_1 = 3'd1;
    localparam logic [2:0] REG_RATE_PERIOD_2 = 3'd2;
    localparam logic [2:0] REG_RATE_PERIOD_3 = 3'd3;
    localparam logic [2:0] REG_DOUBLE_WINDOW = 3'd4;
    localparam logic [2:0] REG_COOLDOWN      = 3'd5;

    // register reset values
    localparam logic [15:0] RATE_PERIOD_0_RST = 16'd250;
    localparam logic [15:0] RATE_PERIOD_1_RST = 16'd500;
    localparam logic [15:0] RATE_PERIOD_2_RST = 16'd1000;
    localparam logic [15:0] RATE_PERIOD_3_RST = 16'd2000;
    localparam logic [9:0]  DOUBLE_WINDOW_RST = 10'd300;
    localparam logic [9:0]  COOLDOWN_RST      = 10'd50;

    typedef struct packed {
        logic [3:0][15:0] rate_period;
        logic [9:0]       double_window;
        logic [9:0]       cooldown;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [9:0]  phase_timer;
        logic [1:0]  sel_index;
        logic [15:0] active_period;
        logic [15:0] blink_timer;
        logic        led_level;
    } state_t;

    typedef struct packed {
        logic [15:0] blink_period;
        logic [1:0]  rate_index;
        logic [1:0]  click_event;
        logic        led_on;
    } result_t;

endpackage

// ----- hw/rtl/click_type_blink_rate_selector.sv -----
// ----------------------------------------------------------------------------
// click_type_blink_rate_selector
// Single/double click detector that steps a blink rate and drives an LED.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: button_pressed
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: led_on, click_event,
//           |           |                    |          rate_index, blink_period
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One tick per cycle unless m_tready stalls: the state update is a single
//  combinational pass from the state registers into the result register.
//  A new tick is taken whenever the result register is empty or drained in
//  the same cycle, so a stalled m_tready stalls s_tready after one result.
//  Reset loads the register defaults and clears the phase machine; the
//  configuration port is always ready.
// ----------------------------------------------------------------------------
`include "click_type_blink_rate_selector_defines.svh"

module click_type_blink_rate_selector
    import ctbrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] button_pressed, [7:1] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] led_on, [2:1] click_event,
                                   // [4:3] rate_index, [20:5] blink_period, [23:21] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    ctbrs_step u_step (
        .cfg            (cfg_reg),
        .cur            (state_reg),
        .button_pressed (s_tdata[0]),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_period[0] <= RATE_PERIOD_0_RST;
            cfg_reg.rate_period[1] <= RATE_PERIOD_1_RST;
            cfg_reg.rate_period[2] <= RATE_PERIOD_2_RST;
            cfg_reg.rate_period[3] <= RATE_PERIOD_3_RST;
            cfg_reg.double_window  <= DOUBLE_WINDOW_RST;
            cfg_reg.cooldown       <= COOLDOWN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RATE_PERIOD_0: cfg_reg.rate_period[0] <= cfg_data;
                REG_RATE_PERIOD_1: cfg_reg.rate_period[1] <= cfg_data;
                REG_RATE_PERIOD_2: cfg_reg.rate_period[2] <= cfg_data;
                REG_RATE_PERIOD_3: cfg_reg.rate_period[3] <= cfg_data;
                REG_DOUBLE_WINDOW: cfg_reg.double_window  <= cfg_data[9:0];
                REG_COOLDOWN:      cfg_reg.cooldown       <= cfg_data[9:0];
                default:           ; // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.phase_timer   <= '0;
            state_reg.sel_index     <= '0;
            state_reg.active_period <= RATE_PERIOD_0_RST;
            state_reg.blink_timer   <= '0;
            state_reg.led_level     <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else if (s_accept)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg.blink_period, res_reg.rate_index,
                       res_reg.click_event, res_reg.led_on};

    // a single click steps the index up by one
    `CTBRS_ASSERT(a_single_steps_up,
        s_accept && res_next.click_event == EV_SINGLE |=>
            state_reg.sel_index == $past(state_reg.sel_index) + 2'd1)
    // a decided click restarts the blink counter
    `CTBRS_ASSERT(a_click_clears_blink,
        s_accept && res_next.click_event != EV_NONE |=> state_reg.blink_timer == 16'd0)
    // input stalls only behind a pending result
    `CTBRS_ASSERT(a_stall_needs_result, !s_tready |-> m_tvalid)
    // blink counter stays below its limit
    `CTBRS_ASSERT(a_blink_below_limit,
        state_reg.blink_timer < state_reg.active_period || state_reg.blink_timer == 16'd0)

endmodule

// ----- hw/rtl/ctbrs_step.sv -----
// ----------------------------------------------------------------------------
// ctbrs_step
// One-tick update: click phase machine, rate stepping and LED blink counter.
// ----------------------------------------------------------------------------
module ctbrs_step
    import ctbrs_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  cur,
    input  logic    button_pressed,
    output state_t  nxt,
    output result_t res
);

    logic [1:0]  ev;
    logic [9:0]  pt_inc;
    logic        win_hit;
    logic [15:0] limit;
    logic [16:0] bt_inc;

    assign pt_inc  = cur.phase_timer + 10'd1;
    assign win_hit = ({1'b0, cur.phase_timer} + 11'd1) >= {1'b0, cfg.double_window};
    // a zero half-period times like one
    assign limit   = (cur.active_period == 16'd0) ? 16'd1 : cur.active_period;
    assign bt_inc  = {1'b0, cur.blink_timer} + 17'd1;

    always_comb
    begin
        nxt = cur;
        ev  = EV_NONE;

        unique case (cur.phase)
            PH_REL1:
            begin
                if (!button_pressed)
                begin
                    nxt.phase       = PH_WINDOW;
                    nxt.phase_timer = '0;
                end
            end
            PH_WINDOW:
            begin
                if (button_pressed)
                    nxt.phase = PH_REL2;
                else if (win_hit)
                    ev = EV_SINGLE;
                else
                    nxt.phase_timer = pt_inc;
            end
            PH_REL2:
            begin
                if (!button_pressed)
                    ev = EV_DOUBLE;
            end
            PH_COOL:
            begin
                if (pt_inc >= cfg.cooldown)
                begin
                    nxt.phase       = PH_IDLE;
                    nxt.phase_timer = '0;
                end
                else
                begin
                    nxt.phase_timer = pt_inc;
                end
            end
            default:
            begin
                // idle and unused codes: a press enters REL1, else the phase goes to idle
                nxt.phase = button_pressed ? PH_REL1 : PH_IDLE;
            end
        endcase

        if (ev != EV_NONE)
        begin
            nxt.sel_index     = (ev == EV_SINGLE) ? cur.sel_index + 2'd1 : cur.sel_index - 2'd1;
            nxt.active_period = cfg.rate_period[nxt.sel_index];
            nxt.blink_timer   = '0;
            nxt.phase_timer   = '0;
            nxt.phase         = (cfg.cooldown == 10'd0) ? PH_IDLE : PH_COOL;
        end
        else if (bt_inc >= {1'b0, limit})
        begin
            nxt.led_level   = ~cur.led_level;
            nxt.blink_timer = '0;
        end
        else
        begin
            nxt.blink_timer = bt_inc[15:0];
        end

        res.led_on       = nxt.led_level;
        res.click_event  = ev;
        res.rate_index   = nxt.sel_index;
        res.blink_period = nxt.active_period;
    end

endmodule
